// ----- rtl/ple_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Positional list engine package
// Operation codes, result status codes and the cell command beat.
// ----------------------------------------------------------------------------
package ple_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned POS_W   = 6;
   localparam int unsigned OP_W    = 3;
   localparam int unsigned IDX_W   = 6;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned MAX_OUT = 32;

   localparam logic [OP_W-1:0] OP_INS_FIRST = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_LAST  = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
   localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd3;
   localparam logic [OP_W-1:0] OP_DEL_LAST  = 3'd4;
   localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
   localparam logic [OP_W-1:0] OP_DUMP      = 3'd6;

   localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
   localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd3;

   typedef logic [1:0] ple_code_type;

   localparam ple_code_type CMD_HOLD = 2'd0;
   localparam ple_code_type CMD_INS  = 2'd1;
   localparam ple_code_type CMD_DEL  = 2'd2;
   localparam ple_code_type CMD_ROT  = 2'd3;

   typedef struct packed {
      ple_code_type      code;
      logic [DATA_W-1:0] value;
   } ple_cmd_type;

endpackage
`default_nettype wire

// ----- rtl/ple_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Positional list cell
// Holds one list entry; loads, shifts from a neighbour or takes the head.
// ----------------------------------------------------------------------------
module ple_cell #(
   parameter int unsigned INDEX = 0,
   parameter int unsigned AW    = 5
) (
   input  wire logic                      clock,
   input  wire ple_pkg::ple_cmd_type      cmd,
   input  wire logic [AW-1:0]             slot,
   input  wire logic [AW-1:0]             tail,
   input  wire logic [ple_pkg::DATA_W-1:0] prev_data,
   input  wire logic [ple_pkg::DATA_W-1:0] next_data,
   input  wire logic [ple_pkg::DATA_W-1:0] head_data,
   output logic      [ple_pkg::DATA_W-1:0] data_out
);
   import ple_pkg::*;

   localparam logic [AW-1:0] MY_IDX = AW'(INDEX);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (cmd.code)
         CMD_INS: begin
            if (MY_IDX == slot) begin
               data_in = cmd.value;
            end else if (MY_IDX > slot) begin
               data_in = prev_data;
            end
         end
         CMD_DEL: begin
            if (MY_IDX >= slot) begin
               data_in = next_data;
            end
         end
         CMD_ROT: begin
            if (MY_IDX == tail) begin
               data_in = head_data;
            end else if (MY_IDX < tail) begin
               data_in = next_data;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule
`default_nettype wire

// ----- rtl/positional_list_engine_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Positional list engine core
// Bounded ordered list of signed 32-bit values in a shifting row of cells.
//
//   channel | dir | tdata (low bit up)                          | tuser  | tlast
//   req_    | in  | value[31:0], position[37:32], pad           | op     | -
//   rsp_    | out | element[31:0], element_index[37:32],        | status | last
//           |     | count[43:38], pad                           |        |
//
// Insert, delete and unknown ops give one beat each.
// A dump rotates the row count times, once per cycle unless a beat waits;
// it gives one beat per element for the first 32; an empty dump gives one beat.
// The result register holds a beat while rsp_tready is low; a new beat is
// taken only when the result register is free or being drained.
// Synchronous reset empties the list; cell contents are left as they are.
// ----------------------------------------------------------------------------
module positional_list_engine_core #(
   parameter int unsigned DEPTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // value[31:0], position[37:32], zero pad
   input  wire logic [2:0]  req_tuser,   // op[2:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [47:0] rsp_tdata,   // element[31:0], element_index[37:32],
                                         // count[43:38], zero pad
   output logic      [1:0]  rsp_tuser,   // status[1:0]
   output logic             rsp_tlast
);
   import ple_pkg::*;

   localparam int unsigned AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW       = $clog2(DEPTH + 1);
   localparam int unsigned PW       = ((CW > POS_W) ? CW : POS_W) + 1;
   localparam int unsigned MAX_EMIT = (DEPTH < MAX_OUT) ? DEPTH : MAX_OUT;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_DUMP = 1'b1;

   logic                state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       rot_ff, rot_in;
   logic                valid_ff, valid_in;
   logic [DATA_W-1:0]   elem_ff, elem_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;
   logic [STAT_W-1:0]   stat_ff, stat_in;
   logic                last_ff, last_in;

   ple_cmd_type         cmd;
   logic [AW-1:0]       slot;
   logic [AW-1:0]       tail;
   logic [DATA_W-1:0]   cell_data [DEPTH];

   logic [OP_W-1:0]     req_op;
   logic [DATA_W-1:0]   req_value;
   logic [POS_W-1:0]    req_position;
   logic                out_free;
   logic                accept;
   logic [PW-1:0]       pos_ext;
   logic [PW-1:0]       cnt_ext;
   logic                full;
   logic [CW-1:0]       n_emit;

   assign req_op       = req_tuser;
   assign req_value    = req_tdata[31:0];
   assign req_position = req_tdata[37:32];

   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign pos_ext    = PW'(req_position);
   assign cnt_ext    = PW'(count_ff);
   assign full       = (cnt_ext >= PW'(DEPTH));
   assign n_emit     = (count_ff > CW'(MAX_EMIT)) ? CW'(MAX_EMIT) : count_ff;
   assign tail       = AW'(count_ff - CW'(1));

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      rot_in    = rot_ff;
      valid_in  = valid_ff && !rsp_tready;
      elem_in   = elem_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      stat_in   = stat_ff;
      last_in   = last_ff;
      cmd.code  = CMD_HOLD;
      cmd.value = req_value;
      slot      = '0;

      if (state_ff == S_IDLE) begin
         if (accept) begin
            valid_in = 1'b1;
            elem_in  = '0;
            idx_in   = '0;
            stat_in  = STAT_OK;
            last_in  = 1'b1;
            case (req_op)
               OP_INS_FIRST, OP_INS_LAST: begin
                  if (full) begin
                     stat_in = STAT_FULL;
                  end else begin
                     cmd.code = CMD_INS;
                     slot     = (req_op == OP_INS_FIRST) ? '0 : AW'(count_ff);
                     count_in = count_ff + CW'(1);
                  end
               end
               OP_INS_AT: begin
                  if (pos_ext == '0 || pos_ext > cnt_ext + PW'(1)) begin
                     stat_in = STAT_BADPOS;
                  end else if (full) begin
                     stat_in = STAT_FULL;
                  end else begin
                     cmd.code = CMD_INS;
                     slot     = AW'(pos_ext - PW'(1));
                     count_in = count_ff + CW'(1);
                  end
               end
               OP_DEL_FIRST, OP_DEL_LAST: begin
                  if (count_ff == '0) begin
                     stat_in = STAT_EMPTY;
                  end else begin
                     cmd.code = CMD_DEL;
                     slot     = (req_op == OP_DEL_FIRST) ? '0 : tail;
                     count_in = count_ff - CW'(1);
                  end
               end
               OP_DEL_AT: begin
                  if (pos_ext == '0 || pos_ext > cnt_ext) begin
                     stat_in = STAT_BADPOS;
                  end else begin
                     cmd.code = CMD_DEL;
                     slot     = AW'(pos_ext - PW'(1));
                     count_in = count_ff - CW'(1);
                  end
               end
               OP_DUMP: begin
                  if (count_ff != '0) begin
                     cmd.code = CMD_ROT;
                     elem_in  = cell_data[0];
                     idx_in   = IDX_W'(1);
                     last_in  = (n_emit == CW'(1));
                     rot_in   = CW'(1);
                     if (count_ff != CW'(1)) begin
                        state_in = S_DUMP;
                     end
                  end
               end
               default: stat_in = STAT_OK;
            endcase
            cnt_in = IDX_W'(count_in);
         end
      end else begin
         if (rot_ff >= n_emit || out_free) begin
            cmd.code = CMD_ROT;
            rot_in   = rot_ff + CW'(1);
            if (rot_ff < n_emit) begin
               valid_in = 1'b1;
               elem_in  = cell_data[0];
               idx_in   = IDX_W'(rot_ff + CW'(1));
               cnt_in   = IDX_W'(count_ff);
               stat_in  = STAT_OK;
               last_in  = (rot_ff + CW'(1) == n_emit);
            end
            if (rot_ff + CW'(1) == count_ff) begin
               state_in = S_IDLE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rot_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rot_ff   <= rot_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
      idx_ff  <= idx_in;
      cnt_ff  <= cnt_in;
      stat_ff <= stat_in;
      last_ff <= last_in;
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_W-1:0] prev_d;
      logic [DATA_W-1:0] next_d;

      if (g == 0) begin : g_first
         assign prev_d = req_value;
      end else begin : g_mid
         assign prev_d = cell_data[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign next_d = cell_data[g];
      end else begin : g_inner
         assign next_d = cell_data[g+1];
      end

      ple_cell #(
         .INDEX (g),
         .AW    (AW)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .slot      (slot),
         .tail      (tail),
         .prev_data (prev_d),
         .next_data (next_d),
         .head_data (cell_data[0]),
         .data_out  (cell_data[g])
      );
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'd0, cnt_ff, idx_ff, elem_ff};
   assign rsp_tuser  = stat_ff;
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire
